>>> design/bilinear_2d_histogram_defines.svh
// Assertion macros used by the histogram datapath RTL.
`ifndef BILINEAR_2D_HISTOGRAM_DEFINES_SVH
`define BILINEAR_2D_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define BL2DH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bl2dh: same-cycle check failed");
`define BL2DH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bl2dh: next-cycle check failed");
`else
`define BL2DH_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BL2DH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/bl2dh_pkg.sv
// Shared types, codes and widths of the 2D linear-binning histogram.
package bl2dh_pkg;

    localparam int GRID_POINTS_DEF = 64;
    localparam int VAL_W           = 32;
    localparam int PPA_W           = 7;
    localparam int CELL_W          = 48;
    localparam int FRAC_W          = 16;
    localparam int IDX_W           = 6;
    localparam int DIV_RW          = 32;
    localparam int DVD_W           = PPA_W + VAL_W + FRAC_W;
    // |index * span| stays below 2^38
    localparam int COORD_STEPS     = 38;
    localparam int APB_AW          = 5;
    localparam int APB_DW          = 32;

    localparam logic [2:0] REG_X_LOWER = 3'd0;
    localparam logic [2:0] REG_X_UPPER = 3'd1;
    localparam logic [2:0] REG_Y_LOWER = 3'd2;
    localparam logic [2:0] REG_Y_UPPER = 3'd3;
    localparam logic [2:0] REG_POINTS  = 3'd4;

    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [1:0] {
        STAT_DEPOSITED = 2'd0,
        STAT_DROPPED   = 2'd1,
        STAT_READ      = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WGT,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_RD_CELL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_lower;
        logic signed [VAL_W-1:0] x_upper;
        logic signed [VAL_W-1:0] y_lower;
        logic signed [VAL_W-1:0] y_upper;
        logic [PPA_W-1:0]        points;
    } t_cfg;

    typedef struct packed {
        logic       clr_wr;
        logic       capture;
        logic       mul;
        logic       div_start;
        logic       div_store;
        logic       wgt;
        logic       upd_rd;
        logic       upd_wr;
        logic       cell_rd;
        logic       load_out;
        logic       axis;
        logic [1:0] corner;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic op_read;
        logic drop;
        logic idx_bad;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

>>> design/bl2dh_regs.sv
// APB configuration registers: bounds and points per axis.
module bl2dh_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bl2dh_pkg::APB_AW-1:0]  paddr,
    input  logic [bl2dh_pkg::APB_DW-1:0]  pwdata,
    output logic [bl2dh_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output bl2dh_pkg::t_cfg               o_cfg
);

    logic signed [bl2dh_pkg::VAL_W-1:0] r_x_lower, r_x_upper, r_y_lower, r_y_upper;
    logic [bl2dh_pkg::PPA_W-1:0]        r_points;
    logic                               wr_en;
    logic [2:0]                         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[bl2dh_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lower <= '0;
            r_x_upper <= 32'sd65536;
            r_y_lower <= '0;
            r_y_upper <= 32'sd65536;
            r_points  <= 7'd64;
        end else if (wr_en) begin
            case (reg_idx)
                bl2dh_pkg::REG_X_LOWER: r_x_lower <= $signed(pwdata);
                bl2dh_pkg::REG_X_UPPER: r_x_upper <= $signed(pwdata);
                bl2dh_pkg::REG_Y_LOWER: r_y_lower <= $signed(pwdata);
                bl2dh_pkg::REG_Y_UPPER: r_y_upper <= $signed(pwdata);
                bl2dh_pkg::REG_POINTS:  r_points  <= pwdata[bl2dh_pkg::PPA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bl2dh_pkg::REG_X_LOWER: prdata = r_x_lower;
            bl2dh_pkg::REG_X_UPPER: prdata = r_x_upper;
            bl2dh_pkg::REG_Y_LOWER: prdata = r_y_lower;
            bl2dh_pkg::REG_Y_UPPER: prdata = r_y_upper;
            bl2dh_pkg::REG_POINTS:  prdata = 32'(r_points);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.x_lower = r_x_lower;
    assign o_cfg.x_upper = r_x_upper;
    assign o_cfg.y_lower = r_y_lower;
    assign o_cfg.y_upper = r_y_upper;
    assign o_cfg.points  = r_points;

endmodule

>>> design/bl2dh_div.sv
// Restoring divider, one quotient bit per cycle, shared by both axes.
module bl2dh_div #(
    parameter int GRID_POINTS = bl2dh_pkg::GRID_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_coord,
    input  logic [bl2dh_pkg::DVD_W-1:0]          i_dividend,
    input  logic [bl2dh_pkg::DIV_RW-1:0]         i_divisor,
    output logic                                 o_done,
    output logic [bl2dh_pkg::COORD_STEPS-1:0]    o_quotient,
    output logic                                 o_rem_nz
);

    localparam int DEP_STEPS = $clog2(GRID_POINTS) + bl2dh_pkg::FRAC_W;
    localparam int CNT_W     = $clog2(bl2dh_pkg::COORD_STEPS + 1);
    localparam int RW        = bl2dh_pkg::DIV_RW;
    localparam int DW        = bl2dh_pkg::DVD_W;
    localparam int QW        = bl2dh_pkg::COORD_STEPS;

    logic [RW-1:0]    r_rem;
    logic [DW-1:0]    r_dvd;
    logic [QW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [RW:0]      trial;
    logic             ge;
    logic [RW-1:0]    rem_next;

    assign trial    = {r_rem, r_dvd[DW-1]};
    assign ge       = trial >= {1'b0, i_divisor};
    assign rem_next = ge ? RW'(trial - {1'b0, i_divisor}) : trial[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_coord ? CNT_W'(QW) : CNT_W'(DEP_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient fits the step count, so the high dividend bits start as remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= '0;
            if (i_coord) begin
                r_rem <= RW'(i_dividend >> QW);
                r_dvd <= i_dividend << (DW - QW);
            end else begin
                r_rem <= RW'(i_dividend >> DEP_STEPS);
                r_dvd <= i_dividend << (DW - DEP_STEPS);
            end
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_nz   = r_rem != '0;

endmodule

>>> design/bl2dh_ctrl.sv
// Sequencer: clearing pass, item accept, divisions, cell updates or cell read, result hand-off.
module bl2dh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bl2dh_pkg::t_sts   i_sts,
    output bl2dh_pkg::t_cmd   o_cmd
);

    bl2dh_pkg::t_state r_state, n_state;
    logic              r_axis, n_axis;
    logic [1:0]        r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bl2dh_pkg::ST_CLEAR;
            r_axis   <= 1'b0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_corner <= n_corner;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_corner = r_corner;
        case (r_state)
            bl2dh_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = bl2dh_pkg::ST_IDLE;
            end
            bl2dh_pkg::ST_IDLE: begin
                if (i_valid) n_state = bl2dh_pkg::ST_DECIDE;
            end
            bl2dh_pkg::ST_DECIDE: begin
                n_axis = 1'b0;
                if (i_sts.op_read ? i_sts.idx_bad : i_sts.drop) begin
                    n_state = bl2dh_pkg::ST_FINISH;
                end else begin
                    n_state = bl2dh_pkg::ST_MUL;
                end
            end
            bl2dh_pkg::ST_MUL:    n_state = bl2dh_pkg::ST_DIV_GO;
            bl2dh_pkg::ST_DIV_GO: n_state = bl2dh_pkg::ST_DIV_WAIT;
            bl2dh_pkg::ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = bl2dh_pkg::ST_MUL;
                    end else if (i_sts.op_read) begin
                        n_state = bl2dh_pkg::ST_RD_CELL;
                    end else begin
                        n_state = bl2dh_pkg::ST_WGT;
                    end
                end
            end
            bl2dh_pkg::ST_WGT: begin
                n_corner = '0;
                n_state  = bl2dh_pkg::ST_UPD_RD;
            end
            bl2dh_pkg::ST_UPD_RD: n_state = bl2dh_pkg::ST_UPD_WR;
            bl2dh_pkg::ST_UPD_WR: begin
                n_corner = r_corner + 2'd1;
                n_state  = (r_corner == 2'd3) ? bl2dh_pkg::ST_FINISH : bl2dh_pkg::ST_UPD_RD;
            end
            bl2dh_pkg::ST_RD_CELL: n_state = bl2dh_pkg::ST_FINISH;
            bl2dh_pkg::ST_FINISH: begin
                if (i_sts.out_free) n_state = bl2dh_pkg::ST_IDLE;
            end
            default: n_state = bl2dh_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.axis   = r_axis;
        o_cmd.corner = r_corner;
        o_stall      = r_state != bl2dh_pkg::ST_IDLE;
        case (r_state)
            bl2dh_pkg::ST_CLEAR:    o_cmd.clr_wr    = 1'b1;
            bl2dh_pkg::ST_IDLE:     o_cmd.capture   = i_valid;
            bl2dh_pkg::ST_MUL:      o_cmd.mul       = 1'b1;
            bl2dh_pkg::ST_DIV_GO:   o_cmd.div_start = 1'b1;
            bl2dh_pkg::ST_DIV_WAIT: o_cmd.div_store = i_sts.div_done;
            bl2dh_pkg::ST_WGT:      o_cmd.wgt       = 1'b1;
            bl2dh_pkg::ST_UPD_RD:   o_cmd.upd_rd    = 1'b1;
            bl2dh_pkg::ST_UPD_WR:   o_cmd.upd_wr    = 1'b1;
            bl2dh_pkg::ST_RD_CELL:  o_cmd.cell_rd   = 1'b1;
            bl2dh_pkg::ST_FINISH:   o_cmd.load_out  = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> design/bl2dh_dp.sv
// Datapath: item capture, grid scaling, weights, cell memory and output register.
`include "bilinear_2d_histogram_defines.svh"
module bl2dh_dp #(
    parameter int GRID_POINTS = bl2dh_pkg::GRID_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bl2dh_pkg::t_cfg                    i_cfg,
    input  bl2dh_pkg::t_cmd                    i_cmd,
    output bl2dh_pkg::t_sts                    o_sts,
    input  logic                               i_operation,
    input  logic signed [bl2dh_pkg::VAL_W-1:0] i_x_value,
    input  logic signed [bl2dh_pkg::VAL_W-1:0] i_y_value,
    input  logic [bl2dh_pkg::IDX_W-1:0]        i_x_cell,
    input  logic [bl2dh_pkg::IDX_W-1:0]        i_y_cell,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic [bl2dh_pkg::CELL_W-1:0]       o_density,
    output logic signed [bl2dh_pkg::VAL_W-1:0] o_x_coord,
    output logic signed [bl2dh_pkg::VAL_W-1:0] o_y_coord
);

    localparam int IW     = $clog2(GRID_POINTS);
    localparam int DEPTH  = GRID_POINTS * GRID_POINTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int VW     = bl2dh_pkg::VAL_W;
    localparam int PW     = bl2dh_pkg::PPA_W;
    localparam int CW     = bl2dh_pkg::CELL_W;
    localparam int FW     = bl2dh_pkg::FRAC_W;
    localparam int DW     = bl2dh_pkg::DVD_W;
    localparam int RW     = bl2dh_pkg::DIV_RW;
    localparam int QW     = bl2dh_pkg::COORD_STEPS;
    localparam int DEP_QW = IW + FW;

    // captured item
    logic                   r_op;
    logic signed [VW-1:0]   r_x, r_y;
    logic [bl2dh_pkg::IDX_W-1:0] r_xc, r_yc;

    logic [PW-1:0]          p_eff, pm1;
    logic                   drop, idx_bad, op_read;

    logic signed [VW-1:0]   sel_v, sel_lo, sel_hi;
    logic [bl2dh_pkg::IDX_W-1:0] sel_idx;
    logic signed [VW:0]     span;
    logic [VW-1:0]          off;
    logic [PW+VW-1:0]       dep_prod;
    logic signed [PW-1:0]   idx_s;
    logic signed [VW+7:0]   coord_prod;
    logic [QW-1:0]          coord_mag;

    logic [DW-1:0]          r_dvd;
    logic [RW-1:0]          r_dvs;
    logic                   r_neg;

    logic                   div_done, rem_nz;
    logic [QW-1:0]          quo;
    logic [VW-1:0]          adj, coord_val;

    logic [IW-1:0]          r_fx, r_fy;
    logic [FW-1:0]          r_dx, r_dy, r_wcc;
    logic signed [VW-1:0]   r_xcoord, r_ycoord;
    logic [2*FW-1:0]        dd_prod;
    logic [FW:0]            w_ff, w_cf, w_fc, cor_w;
    logic [IW-1:0]          cor_i, cor_j;
    logic [AW-1:0]          corner_addr, cell_addr;

    logic [CW-1:0]          r_mem [DEPTH];
    logic [CW-1:0]          r_rdata;
    logic [AW-1:0]          r_clr_cnt;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [CW-1:0]          mem_wdata, sat_sum;
    logic [CW:0]            sum_ext;

    logic                   r_out_valid;
    bl2dh_pkg::t_status     r_status, res_status;
    logic [CW-1:0]          r_density;
    logic signed [VW-1:0]   r_ox, r_oy;
    logic                   out_free;

    // points per axis clamped to 2..GRID_POINTS
    always_comb begin
        if (i_cfg.points < PW'(2)) begin
            p_eff = PW'(2);
        end else if ({2'b00, i_cfg.points} > 9'(GRID_POINTS)) begin
            p_eff = PW'(GRID_POINTS);
        end else begin
            p_eff = i_cfg.points;
        end
    end
    assign pm1 = p_eff - PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_x  <= i_x_value;
            r_y  <= i_y_value;
            r_xc <= i_x_cell;
            r_yc <= i_y_cell;
        end
    end

    assign op_read = r_op == bl2dh_pkg::OP_READ;
    assign drop    = (r_x <= i_cfg.x_lower) || (r_x >= i_cfg.x_upper)
                  || (r_y <= i_cfg.y_lower) || (r_y >= i_cfg.y_upper);
    assign idx_bad = ({1'b0, r_xc} >= p_eff) || ({1'b0, r_yc} >= p_eff);

    // axis operands
    assign sel_v   = i_cmd.axis ? r_y : r_x;
    assign sel_lo  = i_cmd.axis ? i_cfg.y_lower : i_cfg.x_lower;
    assign sel_hi  = i_cmd.axis ? i_cfg.y_upper : i_cfg.x_upper;
    assign sel_idx = i_cmd.axis ? r_yc : r_xc;

    assign span       = (VW+1)'(sel_hi) - (VW+1)'(sel_lo);
    assign off        = sel_v - sel_lo;
    assign dep_prod   = (PW+VW)'(pm1) * (PW+VW)'(off);
    assign idx_s      = {1'b0, sel_idx};
    assign coord_prod = (VW+8)'(idx_s) * (VW+8)'(span);
    assign coord_mag  = coord_prod[VW+7] ? QW'(-coord_prod) : coord_prod[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_neg <= coord_prod[VW+7];
            if (op_read) begin
                r_dvd <= DW'(coord_mag);
                r_dvs <= RW'(pm1);
            end else begin
                r_dvd <= {dep_prod, FW'(0)};
                r_dvs <= span[VW-1:0];
            end
        end
    end

    bl2dh_div #(
        .GRID_POINTS (GRID_POINTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_coord    (op_read),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quotient (quo),
        .o_rem_nz   (rem_nz)
    );

    // floor division: round a negative quotient away from zero on a remainder
    assign adj       = quo[VW-1:0] + VW'(r_neg & rem_nz);
    assign coord_val = sel_lo + (r_neg ? -adj : adj);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (op_read) begin
                if (i_cmd.axis) r_ycoord <= coord_val;
                else            r_xcoord <= coord_val;
            end else if (i_cmd.axis) begin
                r_fy <= quo[DEP_QW-1:FW];
                r_dy <= quo[FW-1:0];
            end else begin
                r_fx <= quo[DEP_QW-1:FW];
                r_dx <= quo[FW-1:0];
            end
        end
    end

    assign dd_prod = (2*FW)'(r_dx) * (2*FW)'(r_dy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wgt) begin
            r_wcc <= FW'(((2*FW+1)'(dd_prod) + (2*FW+1)'(32768)) >> FW);
        end
    end

    assign w_ff = (FW+1)'(18'd65536 - 18'(r_dx) - 18'(r_dy) + 18'(r_wcc));
    assign w_cf = (FW+1)'(r_dx) - (FW+1)'(r_wcc);
    assign w_fc = (FW+1)'(r_dy) - (FW+1)'(r_wcc);

    always_comb begin
        cor_i = i_cmd.corner[1] ? r_fx + IW'(1) : r_fx;
        cor_j = i_cmd.corner[0] ? r_fy + IW'(1) : r_fy;
        case (i_cmd.corner)
            2'd0:    cor_w = w_ff;
            2'd1:    cor_w = w_fc;
            2'd2:    cor_w = w_cf;
            default: cor_w = (FW+1)'(r_wcc);
        endcase
    end

    assign corner_addr = AW'(cor_i) * AW'(GRID_POINTS) + AW'(cor_j);
    assign cell_addr   = AW'(IW'(r_xc)) * AW'(GRID_POINTS) + AW'(IW'(r_yc));

    // saturating accumulate
    assign sum_ext = (CW+1)'(r_rdata) + (CW+1)'(cor_w);
    assign sat_sum = sum_ext[CW] ? '1 : sum_ext[CW-1:0];

    assign mem_we    = i_cmd.clr_wr | i_cmd.upd_wr;
    assign mem_waddr = i_cmd.clr_wr ? r_clr_cnt : corner_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : sat_sum;
    assign mem_re    = i_cmd.upd_rd | i_cmd.cell_rd;
    assign mem_raddr = i_cmd.cell_rd ? cell_addr : corner_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // output word
    always_comb begin
        if (op_read) begin
            res_status = idx_bad ? bl2dh_pkg::STAT_BAD_INDEX : bl2dh_pkg::STAT_READ;
        end else begin
            res_status = drop ? bl2dh_pkg::STAT_DROPPED : bl2dh_pkg::STAT_DEPOSITED;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= res_status;
            if (res_status == bl2dh_pkg::STAT_READ) begin
                r_density <= r_rdata;
                r_ox      <= r_xcoord;
                r_oy      <= r_ycoord;
            end else begin
                r_density <= '0;
                r_ox      <= '0;
                r_oy      <= '0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_density = r_density;
    assign o_x_coord = r_ox;
    assign o_y_coord = r_oy;

    assign o_sts.clr_last = r_clr_cnt == AW'(DEPTH - 1);
    assign o_sts.op_read  = op_read;
    assign o_sts.drop     = drop;
    assign o_sts.idx_bad  = idx_bad;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    `BL2DH_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out, out_free)
    `BL2DH_ASSERT_NOW(a_weights_unit, i_clk, i_rst_n, i_cmd.upd_wr, (18'(w_ff) + 18'(w_cf) + 18'(w_fc) + 18'(r_wcc)) == 18'd65536)
    `BL2DH_ASSERT_NOW(a_corner_in_grid, i_clk, i_rst_n, i_cmd.upd_wr, (9'(r_fx) + 9'd1 < 9'(p_eff)) && (9'(r_fy) + 9'd1 < 9'(p_eff)))
    `BL2DH_ASSERT_NEXT(a_read_then_write, i_clk, i_rst_n, i_cmd.upd_rd, i_cmd.upd_wr)
    `BL2DH_ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n, i_cmd.clr_wr && o_sts.clr_last, !i_cmd.clr_wr)

endmodule

>>> design/bilinear_2d_histogram.sv
// Top level of the 2D linear-binning histogram.
// Input channel: i_valid / o_stall with i_operation, i_x_value, i_y_value,
//   i_x_cell, i_y_cell; a word is taken when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall with o_status, o_density, o_x_coord,
//   o_y_coord; one result word per input word, held while i_stall is high.
// Configuration: APB registers at byte addresses 0x00..0x10 (bounds, points).
// One item is in work at a time. With G = GRID_POINTS and Q = clog2(G) + 16:
//   dropped sample or bad read index: no division, straight to the result,
//   deposit: two serial divisions of Q steps, then four read-modify-write
//   passes over the grid, each a read state and a write state,
//   cell read: two 38-step floor divisions, then a cell read.
// Both divisions run on the shared bit-serial divider.
// The next word is taken in the cycle after a result is loaded, when the
//   sequencer is back in its idle state.
// After reset the grid is swept to zero, one cell per cycle, over all G*G
//   cells (4096 at the default); o_stall stays high meanwhile.
// A finished result waits in the output register; the next word is accepted
//   while it waits, and the block holds its following result until it drains.
module bilinear_2d_histogram #(
    parameter int GRID_POINTS = bl2dh_pkg::GRID_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_operation,
    input  logic signed [bl2dh_pkg::VAL_W-1:0] i_x_value,
    input  logic signed [bl2dh_pkg::VAL_W-1:0] i_y_value,
    input  logic [bl2dh_pkg::IDX_W-1:0]        i_x_cell,
    input  logic [bl2dh_pkg::IDX_W-1:0]        i_y_cell,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic [bl2dh_pkg::CELL_W-1:0]       o_density,
    output logic signed [bl2dh_pkg::VAL_W-1:0] o_x_coord,
    output logic signed [bl2dh_pkg::VAL_W-1:0] o_y_coord,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bl2dh_pkg::APB_AW-1:0]       paddr,
    input  logic [bl2dh_pkg::APB_DW-1:0]       pwdata,
    output logic [bl2dh_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);

    bl2dh_pkg::t_cfg cfg;
    bl2dh_pkg::t_cmd cmd;
    bl2dh_pkg::t_sts sts;

    bl2dh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bl2dh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bl2dh_dp #(
        .GRID_POINTS (GRID_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_x_cell    (i_x_cell),
        .i_y_cell    (i_y_cell),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_density   (o_density),
        .o_x_coord   (o_x_coord),
        .o_y_coord   (o_y_coord)
    );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the 2D linear-binning histogram.
`timescale 1ns / 1ps

module testbench;

    localparam int G = 64;
    localparam longint CELL_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] density;
        logic [31:0] x_coord;
        logic [31:0] y_coord;
    } t_hist_res;

    typedef struct {
        logic        op;
        logic [31:0] xv;
        logic [31:0] yv;
        logic [5:0]  xc;
        logic [5:0]  yc;
        logic        has_res;
        t_hist_res   res;
    } t_stim_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_operation, o_valid, i_stall;
    logic signed [31:0] i_x_value, i_y_value, o_x_coord, o_y_coord;
    logic [5:0] i_x_cell, i_y_cell;
    logic [1:0] o_status;
    logic [47:0] o_density;
    logic psel, penable, pwrite, pready;
    logic [bl2dh_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;

    bilinear_2d_histogram DUT (.*);

    // shadow of the block
    logic [31:0] sh_xl, sh_xh, sh_yl, sh_yh;
    logic [6:0]  sh_pts;
    logic [47:0] sh_cells [G*G];
    t_hist_res   pending_results [$];
    int          fail_count;
    bit          hold_rx;   // long receiver hold-off
    bit          no_idle;   // stretch with no idling

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int eff_points();
        if (sh_pts < 2) return 2;
        if (sh_pts > G) return G;
        return int'(sh_pts);
    endfunction

    function automatic longint unsigned grid_position(longint v, longint lo, longint hi,
                                                      int pts);
        longint unsigned off, span;
        off = v - lo;
        span = hi - lo;
        return ((longint'(pts - 1) * off) << 16) / span;
    endfunction

    function automatic logic [31:0] grid_coord(int idx, longint lo, longint hi, int pts);
        longint prod, d, q;
        prod = longint'(idx) * (hi - lo);
        d = pts - 1;
        if (prod >= 0) q = prod / d;
        else q = -((-prod + d - 1) / d);
        return 32'(lo + q);
    endfunction

    function automatic void add_weight(int i, int j, longint unsigned w);
        longint unsigned s;
        if (i >= G || j >= G) return;
        s = sh_cells[i*G+j] + w;
        sh_cells[i*G+j] = (s > CELL_MAX) ? 48'(CELL_MAX) : 48'(s);
    endfunction

    function automatic t_hist_res predict_histogram(t_stim_row w);
        t_hist_res r;
        int pts, fx, fy;
        longint xl, xh, yl, yh, x, y;
        longint unsigned xi, yi, dx, dy, wcc;
        pts = eff_points();
        xl = longint'(signed'(sh_xl)); xh = longint'(signed'(sh_xh));
        yl = longint'(signed'(sh_yl)); yh = longint'(signed'(sh_yh));
        r = '{bl2dh_pkg::STAT_DEPOSITED, 0, 0, 0};
        if (w.op == bl2dh_pkg::OP_DEPOSIT) begin
            x = longint'(signed'(w.xv));
            y = longint'(signed'(w.yv));
            if (x <= xl || x >= xh || y <= yl || y >= yh) begin
                r.status = bl2dh_pkg::STAT_DROPPED;
                return r;
            end
            xi = grid_position(x, xl, xh, pts);
            yi = grid_position(y, yl, yh, pts);
            fx = int'(xi >> 16); dx = xi & 16'hFFFF;
            fy = int'(yi >> 16); dy = yi & 16'hFFFF;
            wcc = (dx * dy + 32768) >> 16;
            add_weight(fx, fy, 65536 - dx - dy + wcc);
            add_weight(fx, fy + 1, dy - wcc);
            add_weight(fx + 1, fy, dx - wcc);
            add_weight(fx + 1, fy + 1, wcc);
        end else if (w.xc >= pts || w.yc >= pts) begin
            r.status = bl2dh_pkg::STAT_BAD_INDEX;
        end else begin
            r.status = bl2dh_pkg::STAT_READ;
            r.density = sh_cells[w.xc*G+w.yc];
            r.x_coord = grid_coord(int'(w.xc), xl, xh, pts);
            r.y_coord = grid_coord(int'(w.yc), yl, yh, pts);
        end
        return r;
    endfunction

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= bl2dh_pkg::APB_AW'(reg_idx) << 2; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (reg_idx)
            bl2dh_pkg::REG_X_LOWER: sh_xl = value;
            bl2dh_pkg::REG_X_UPPER: sh_xh = value;
            bl2dh_pkg::REG_Y_LOWER: sh_yl = value;
            bl2dh_pkg::REG_Y_UPPER: sh_yh = value;
            bl2dh_pkg::REG_POINTS:  sh_pts = value[6:0];
            default: ;
        endcase
    endtask

    task automatic set_bounds(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                              logic [31:0] yh, logic [6:0] pts);
        apb_write(bl2dh_pkg::REG_X_LOWER, xl);
        apb_write(bl2dh_pkg::REG_X_UPPER, xh);
        apb_write(bl2dh_pkg::REG_Y_LOWER, yl);
        apb_write(bl2dh_pkg::REG_Y_UPPER, yh);
        apb_write(bl2dh_pkg::REG_POINTS, {25'd0, pts});
    endtask

    // drop valid and wait until every expected word has come back
    task automatic drain_results();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("TEST FAILED");
            $finish;
        end
        repeat (100) @(posedge i_clk);
    endtask

    // send one word; a typed-in expectation replaces the predicted word
    task automatic send_word(t_stim_row w);
        t_hist_res r;
        if (!no_idle)
            while ($urandom_range(99) < 14) begin
                i_valid <= 0;
                @(posedge i_clk);
            end
        i_valid <= 1; i_operation <= w.op;
        i_x_value <= w.xv; i_y_value <= w.yv;
        i_x_cell <= w.xc; i_y_cell <= w.yc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = predict_histogram(w);
        if (w.has_res && r != w.res) begin
            $display("%0t predictor disagrees with table row: exp %p got %p",
                     $time, w.res, r);
            fail_count++;
        end
        pending_results.push_back(w.has_res ? w.res : r);
    endtask

    function automatic t_stim_row deposit_row(logic [31:0] xv, logic [31:0] yv);
        return '{bl2dh_pkg::OP_DEPOSIT, xv, yv, 0, 0, 0, '{0, 0, 0, 0}};
    endfunction

    function automatic t_stim_row read_row(logic [5:0] xc, logic [5:0] yc);
        return '{bl2dh_pkg::OP_READ, 0, 0, xc, yc, 0, '{0, 0, 0, 0}};
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result word: status %0d", $time, o_status);
                    fail_count++;
                end else begin
                    t_hist_res e;
                    e = pending_results.pop_front();
                    if (o_status != e.status) begin
                        $display("%0t status exp %0d got %0d", $time, e.status, o_status);
                        fail_count++;
                    end
                    if (o_density != e.density) begin
                        $display("%0t density exp %h got %h", $time, e.density, o_density);
                        fail_count++;
                    end
                    if (o_x_coord != e.x_coord) begin
                        $display("%0t x_coord exp %h got %h", $time, e.x_coord, o_x_coord);
                        fail_count++;
                    end
                    if (o_y_coord != e.y_coord) begin
                        $display("%0t y_coord exp %h got %h", $time, e.y_coord, o_y_coord);
                        fail_count++;
                    end
                end
            end
            i_stall <= hold_rx || (!no_idle && $urandom_range(99) < 14);
        end
    end

    function automatic logic [31:0] rand_in(logic [31:0] lo, logic [31:0] hi);
        longint l, h;
        l = longint'(signed'(lo)); h = longint'(signed'(hi));
        if (h - l < 2) return lo;
        return 32'(l + 1 + longint'({$urandom, $urandom} % 64'(h - l - 1)));
    endfunction

    task automatic random_phase(int count, int pct_good);
        t_stim_row w;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0) begin
                // bias reads inside the grid, sometimes out of range
                w = read_row(6'($urandom_range(eff_points() + 2 > 63 ? 63 : eff_points() + 2)),
                             6'($urandom_range(eff_points() + 2 > 63 ? 63 : eff_points() + 2)));
                if ($urandom_range(9) == 0) w = read_row(6'($urandom), 6'($urandom));
            end else if ($urandom_range(99) < pct_good) begin
                w = deposit_row(rand_in(sh_xl, sh_xh), rand_in(sh_yl, sh_yh));
            end else begin
                w = deposit_row($urandom, $urandom);
            end
            send_word(w);
        end
    endtask

    t_stim_row directed_rows [$];

    initial begin
        i_rst_n = 0; i_valid = 0; i_operation = 0; i_x_value = 0; i_y_value = 0;
        i_x_cell = 0; i_y_cell = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        hold_rx = 0; no_idle = 0; fail_count = 0;
        sh_xl = 0; sh_xh = 65536; sh_yl = 0; sh_yh = 65536; sh_pts = 64;
        foreach (sh_cells[k]) sh_cells[k] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed table: reset values, extremes, drops
        directed_rows = '{
            '{bl2dh_pkg::OP_READ, 0, 0, 0, 0, 1, '{bl2dh_pkg::STAT_READ, 0, 0, 0}},
            '{bl2dh_pkg::OP_READ, 0, 0, 63, 63, 1,
              '{bl2dh_pkg::STAT_READ, 0, 32'h10000, 32'h10000}},
            '{bl2dh_pkg::OP_DEPOSIT, 0, 32'h8000, 0, 0, 1,
              '{bl2dh_pkg::STAT_DROPPED, 0, 0, 0}},
            '{bl2dh_pkg::OP_DEPOSIT, 32'h10000, 32'h8000, 0, 0, 1,
              '{bl2dh_pkg::STAT_DROPPED, 0, 0, 0}},
            '{bl2dh_pkg::OP_DEPOSIT, 32'h8000, 32'h7FFFFFFF, 0, 0, 1,
              '{bl2dh_pkg::STAT_DROPPED, 0, 0, 0}},
            '{bl2dh_pkg::OP_DEPOSIT, 32'h80000000, 32'h8000, 0, 0, 1,
              '{bl2dh_pkg::STAT_DROPPED, 0, 0, 0}},
            deposit_row(32'h8000, 32'h8000),
            deposit_row(1, 1),
            deposit_row(32'hFFFF, 32'hFFFF),
            deposit_row(32'h0400, 32'h0400),
            read_row(0, 0), read_row(31, 31), read_row(32, 31), read_row(63, 62),
            read_row(62, 62)
        };
        foreach (directed_rows[k]) send_word(directed_rows[k]);
        drain_results();

        // small grid: bad indexes and zero fractions
        set_bounds(32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 32'h00010000, 3);
        directed_rows = '{
            '{bl2dh_pkg::OP_READ, 0, 0, 3, 0, 1, '{bl2dh_pkg::STAT_BAD_INDEX, 0, 0, 0}},
            '{bl2dh_pkg::OP_READ, 0, 0, 0, 63, 1, '{bl2dh_pkg::STAT_BAD_INDEX, 0, 0, 0}},
            deposit_row(0, 0), read_row(1, 1), read_row(2, 0)
        };
        foreach (directed_rows[k]) send_word(directed_rows[k]);
        drain_results();

        // P below range, upper under lower, full range bounds
        set_bounds(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0);
        send_word(deposit_row(0, 0));
        send_word(read_row(1, 1));
        send_word(read_row(0, 1));
        random_phase(60, 80);
        drain_results();

        set_bounds(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 127);
        random_phase(150, 85);
        // receiver holds off; sender keeps offering
        hold_rx = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_rx = 0;
            end
            begin
                random_phase(20, 90);
                i_valid <= 0;
            end
        join
        drain_results();

        set_bounds(32'hFFFC0000, 32'h00060000, 32'h00010000, 32'h00020000, 5);
        random_phase(150, 85);
        drain_results();

        no_idle = 1;
        set_bounds(32'h00000010, 32'h00000100, 32'hFFFFFF00, 32'h00000050, 64);
        random_phase(120, 90);
        drain_results();
        no_idle = 0;

        set_bounds(32'h80000000, 32'h00000000, 32'h00000000, 32'h7FFFFFFF, 2);
        random_phase(150, 85);
        drain_results();

        // saturation can't occur in a realistic run; still mix in reads of hot cells
        set_bounds(0, 32'h00000004, 0, 32'h00000004, 17);
        random_phase(150, 90);
        drain_results();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
